// File: rtl/core/fcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcp_pkg;

    localparam logic [7:0]  MARK0      = 8'hA5;
    localparam logic [7:0]  MARK1      = 8'h5A;
    localparam logic [16:0] HDR_SIZE   = 17'd5;
    localparam logic [16:0] CRC_SIZE   = 17'd2;
    localparam logic [16:0] POS_MAX    = 17'd65542;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    localparam int          FIFO_DEPTH = 4;
    localparam int          FIFO_AW    = 2;

    localparam logic        KIND_PAYLOAD = 1'b0;
    localparam logic        KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_MARKER_BAD  = 3'd2,
        ST_LENGTH_BAD  = 3'd3,
        ST_CRC_BAD     = 3'd4
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload;
        logic [7:0]  seq;
        status_t     status;
        logic [15:0] length;
        logic        last;
    } result_t;

    // CRC-16-CCITT, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/frame_parser_crc16.sv
`timescale 1ns / 1ps
`default_nettype none

// Length-prefixed frame parser with CRC-16-CCITT check. Feed one buffer byte per
// transaction on the slave side, tlast on the final byte. A byte is parsed in the
// cycle it is accepted (header capture, byte-wide CRC update, payload pass-through)
// and zero, one or two results land in a four-entry result queue: a tentative payload
// byte (tuser 0) and, on the final byte, the verdict (tuser 1, tlast 1). Input
// takes one byte every cycle while the queue has room for two results; the queue
// drains one result per cycle while m_tready is high, so a payload byte that also
// ends the buffer gives two results. Write crc_initial_value (address 0) between buffers.

module frame_parser_crc16 (
    input  wire         clk,
    input  wire         rst_n,
    // APB configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [0:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte input
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,    // [7:0] byte_value
    input  wire         s_tlast,
    // result output
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,    // [7:0] payload_byte, [15:8] sequence_number,
                                    // [18:16] status_code, [34:19] payload_length, [39:35] 0
    output logic [0:0]  m_tuser,    // [0] result_kind
    output logic        m_tlast
);

    localparam logic [0:0] ADDR_CRC_INIT = 1'b0;

    logic [15:0]        crc_init_reg;
    logic [16:0]        pos_reg, pos_next;
    logic [15:0]        crc_reg, crc_next;
    logic [15:0]        len_reg, len_next;
    logic [7:0]         seq_reg, seq_next;
    logic [15:0]        rcrc_reg, rcrc_next;
    logic               mbad_reg, mbad_next;

    logic               in_fire;
    logic               room_two;
    logic               pay_hit;
    logic [16:0]        crc_hi;
    logic [16:0]        count;
    fcp_pkg::status_t   status;
    fcp_pkg::result_t   res_pay, res_ver, push_a, push_b, head;
    logic [1:0]         push_cnt;

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_CRC_INIT) ? {16'h0000, crc_init_reg} : 32'h0;
    assign s_tready = room_two;
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_init_reg <= 16'hFFFF;
        else if (psel && penable && pwrite && pready && paddr == ADDR_CRC_INIT)
            crc_init_reg <= pwdata[15:0];
    end

    always_comb
    begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        len_next  = len_reg;
        seq_next  = seq_reg;
        rcrc_next = rcrc_reg;
        mbad_next = mbad_reg;
        pay_hit   = 1'b0;
        crc_hi    = fcp_pkg::HDR_SIZE + {1'b0, len_reg};
        count     = pos_reg + 17'd1;
        status    = fcp_pkg::ST_OK;
        res_pay   = '0;
        res_ver   = '0;
        push_a    = '0;
        push_b    = '0;
        push_cnt  = 2'd0;

        if (in_fire)
        begin
            if (pos_reg == 17'd0)
            begin
                mbad_next = (s_tdata != fcp_pkg::MARK0);
                crc_next  = fcp_pkg::crc_byte(crc_init_reg, s_tdata);
            end
            else if (pos_reg < fcp_pkg::HDR_SIZE)
            begin
                if (pos_reg == 17'd1 && s_tdata != fcp_pkg::MARK1)
                    mbad_next = 1'b1;
                else if (pos_reg == 17'd2)
                    len_next[7:0] = s_tdata;
                else if (pos_reg == 17'd3)
                    len_next[15:8] = s_tdata;
                else if (pos_reg == 17'd4)
                    seq_next = s_tdata;
                crc_next = fcp_pkg::crc_byte(crc_reg, s_tdata);
            end
            else if (pos_reg < crc_hi)
            begin
                crc_next = fcp_pkg::crc_byte(crc_reg, s_tdata);
                pay_hit  = 1'b1;
            end
            else if (pos_reg == crc_hi)
                rcrc_next[15:8] = s_tdata;
            else if (pos_reg == crc_hi + 17'd1)
                rcrc_next[7:0] = s_tdata;

            res_pay.kind    = fcp_pkg::KIND_PAYLOAD;
            res_pay.payload = s_tdata;
            res_pay.seq     = seq_next;
            res_pay.status  = fcp_pkg::ST_OK;
            res_pay.length  = len_next;
            res_pay.last    = 1'b0;

            if (count < fcp_pkg::HDR_SIZE + fcp_pkg::CRC_SIZE)
                status = fcp_pkg::ST_TOO_SHORT;
            else if (mbad_next)
                status = fcp_pkg::ST_MARKER_BAD;
            else if (count < fcp_pkg::HDR_SIZE + fcp_pkg::CRC_SIZE + {1'b0, len_next})
                status = fcp_pkg::ST_LENGTH_BAD;
            else if (rcrc_next != crc_next)
                status = fcp_pkg::ST_CRC_BAD;

            res_ver.kind    = fcp_pkg::KIND_VERDICT;
            res_ver.payload = 8'h00;
            res_ver.seq     = seq_next;
            res_ver.status  = status;
            res_ver.length  = len_next;
            res_ver.last    = 1'b1;

            if (s_tlast)
            begin
                // clear frame state for the next buffer
                pos_next  = '0;
                crc_next  = crc_init_reg;
                len_next  = '0;
                seq_next  = '0;
                rcrc_next = '0;
                mbad_next = 1'b0;
            end
            else
                pos_next = (pos_reg < fcp_pkg::POS_MAX) ? count : fcp_pkg::POS_MAX;

            if (pay_hit && s_tlast)
            begin
                push_a   = res_pay;
                push_b   = res_ver;
                push_cnt = 2'd2;
            end
            else if (pay_hit)
            begin
                push_a   = res_pay;
                push_cnt = 2'd1;
            end
            else if (s_tlast)
            begin
                push_a   = res_ver;
                push_cnt = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            crc_reg  <= 16'hFFFF;
            len_reg  <= '0;
            seq_reg  <= '0;
            rcrc_reg <= '0;
            mbad_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            len_reg  <= len_next;
            seq_reg  <= seq_next;
            rcrc_reg <= rcrc_next;
            mbad_reg <= mbad_next;
        end
    end

    fcp_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_a     (push_a),
        .push_b     (push_b),
        .room_two   (room_two),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    assign m_tdata = {5'b00000, head.length, head.status, head.seq, head.payload};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

`default_nettype wire

// File: rtl/core/fcp_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module fcp_result_fifo (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire  [1:0]          push_cnt,
    input  wire fcp_pkg::result_t push_a,
    input  wire fcp_pkg::result_t push_b,
    output logic                room_two,
    output logic                head_valid,
    input  wire                 head_ready,
    output fcp_pkg::result_t    head
);

    localparam logic [fcp_pkg::FIFO_AW:0] DEPTH_LESS_TWO =
        (fcp_pkg::FIFO_AW + 1)'(fcp_pkg::FIFO_DEPTH - 2);

    fcp_pkg::result_t               mem [fcp_pkg::FIFO_DEPTH];
    logic [fcp_pkg::FIFO_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [fcp_pkg::FIFO_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [fcp_pkg::FIFO_AW:0]      count_reg, count_next;
    logic                           pop;

    function automatic logic [fcp_pkg::FIFO_AW-1:0] FIFO_AW_EXT(input logic [1:0] n);
        return fcp_pkg::FIFO_AW'(n);
    endfunction

    assign head_valid = (count_reg != '0);
    assign room_two   = (count_reg <= DEPTH_LESS_TWO);
    assign head       = mem[rd_ptr_reg];
    assign pop        = head_valid && head_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW_EXT(push_cnt);
        rd_ptr_next = rd_ptr_reg + {{(fcp_pkg::FIFO_AW-1){1'b0}}, pop};
        count_next  = count_reg + {{(fcp_pkg::FIFO_AW-1){1'b0}}, push_cnt}
                      - {{fcp_pkg::FIFO_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_ptr_reg] <= push_a;
        if (push_cnt == 2'd2)
            mem[wr_ptr_reg + 1'b1] <= push_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: bench/frame_parser_crc16_tb.sv
`timescale 1ns / 1ps

module frame_parser_crc16_tb;

    localparam int          CYCLE_LIMIT   = 40_000;
    localparam int          PHASE_BYTES   = 220;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [0:0]  REG_CRC_INIT  = 1'b0;

    typedef logic [7:0] octet_q_t[$];

    typedef struct packed {
        logic [7:0] value;
        logic       eob;
    } buffer_byte_t;

    typedef struct {
        logic              kind;
        logic [7:0]        pbyte;
        logic [7:0]        seq;
        fcp_pkg::status_t  status;
        logic [15:0]       len;
        logic              last;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] byte_value
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // [7:0] payload_byte, [15:8] sequence_number,
                                    // [18:16] status_code, [34:19] payload_length
    logic [0:0]  m_tuser;           // [0] result_kind
    logic        m_tlast;

    buffer_byte_t  buffer_bytes_q[$];
    frame_result_t frame_results_q[$];

    // parser state mirrored from the block
    logic [15:0] crc_seed = 16'hFFFF;
    logic [16:0] frame_pos = '0;
    logic [15:0] crc_acc = 16'hFFFF;
    logic [15:0] len_field = '0;
    logic [7:0]  seq_field = '0;
    logic [15:0] crc_field = '0;
    logic        marker_err = 1'b0;

    logic        calm = 1'b0;
    int          fail_count = 0;
    int          cycle_count = 0;

    frame_parser_crc16 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic eob);
        int                p;
        int                crc_hi;
        int                count;
        fcp_pkg::status_t  st;
        p = int'(frame_pos);
        crc_hi = int'(fcp_pkg::HDR_SIZE) + int'(len_field);
        if (p == 0)
        begin
            marker_err = (b != fcp_pkg::MARK0);
            crc_acc = crc16_step(crc_seed, b);
        end
        else if (p < int'(fcp_pkg::HDR_SIZE))
        begin
            if (p == 1 && b != fcp_pkg::MARK1)
                marker_err = 1'b1;
            else if (p == 2)
                len_field[7:0] = b;
            else if (p == 3)
                len_field[15:8] = b;
            else if (p == 4)
                seq_field = b;
            crc_acc = crc16_step(crc_acc, b);
        end
        else if (p < crc_hi)
        begin
            crc_acc = crc16_step(crc_acc, b);
            frame_results_q.insert(frame_results_q.size(),
                '{fcp_pkg::KIND_PAYLOAD, b, seq_field, fcp_pkg::ST_OK, len_field, 1'b0});
        end
        else if (p == crc_hi)
            crc_field[15:8] = b;
        else if (p == crc_hi + 1)
            crc_field[7:0] = b;

        if (eob)
        begin
            count = p + 1;
            if (count < int'(fcp_pkg::HDR_SIZE) + int'(fcp_pkg::CRC_SIZE))
                st = fcp_pkg::ST_TOO_SHORT;
            else if (marker_err)
                st = fcp_pkg::ST_MARKER_BAD;
            else if (count < int'(fcp_pkg::HDR_SIZE) + int'(len_field)
                             + int'(fcp_pkg::CRC_SIZE))
                st = fcp_pkg::ST_LENGTH_BAD;
            else if (crc_field != crc_acc)
                st = fcp_pkg::ST_CRC_BAD;
            else
                st = fcp_pkg::ST_OK;
            frame_results_q.insert(frame_results_q.size(),
                '{fcp_pkg::KIND_VERDICT, 8'h00, seq_field, st, len_field, 1'b1});
            frame_pos = '0;
            len_field = '0;
            seq_field = '0;
            crc_field = '0;
            marker_err = 1'b0;
        end
        else
            frame_pos = (p < int'(fcp_pkg::POS_MAX)) ? 17'(p + 1) : fcp_pkg::POS_MAX;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (buffer_bytes_q.size() != 0 && (calm || $urandom_range(99) >= 15))
                begin
                    buffer_byte_t nb;
                    nb = buffer_bytes_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nb.value;
                    s_tlast <= nb.eob;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (frame_results_q.size() == 0)
                begin
                    $error("unexpected result transaction: tdata=%h tuser=%b", m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    frame_result_t r;
                    r = frame_results_q.pop_front();
                    check_field("result_kind", r.kind, m_tuser[0]);
                    check_field("payload_byte", r.pbyte, m_tdata[7:0]);
                    check_field("sequence_number", r.seq, m_tdata[15:8]);
                    check_field("status_code", int'(r.status), m_tdata[18:16]);
                    check_field("payload_length", r.len, m_tdata[34:19]);
                    check_field("last_result", r.last, m_tlast);
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 15);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL frame_parser_crc16");
            $finish;
        end
    end

    task automatic write_crc_seed(input logic [15:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_CRC_INIT;
        pwdata <= {16'h0000, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        crc_seed = v;
    endtask

    // wait for the block to go quiet, then let trailing ignored bytes settle
    task automatic drain();
        @(negedge clk);
        while (buffer_bytes_q.size() != 0 || s_tvalid || frame_results_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic make_frame(output octet_q_t f, input logic [15:0] len,
                              input logic [7:0] seq, input int fill);
        logic [15:0] c;
        f = {};
        f.insert(f.size(), fcp_pkg::MARK0);
        f.insert(f.size(), fcp_pkg::MARK1);
        f.insert(f.size(), len[7:0]);
        f.insert(f.size(), len[15:8]);
        f.insert(f.size(), seq);
        for (int i = 0; i < int'(len); i++)
            f.insert(f.size(), (fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
        c = crc_seed;
        foreach (f[i])
            c = crc16_step(c, f[i]);
        f.insert(f.size(), c[15:8]);
        f.insert(f.size(), c[7:0]);
    endtask

    task automatic queue_buffer(input octet_q_t f);
        foreach (f[i])
            buffer_bytes_q.insert(buffer_bytes_q.size(), '{f[i], i == f.size() - 1});
    endtask

    // mostly well-formed frames, the rest corrupted, truncated, padded or noise
    task automatic random_buffer(output octet_q_t f);
        int          pick;
        int          n;
        logic [15:0] len;
        pick = $urandom_range(99);
        len = ($urandom_range(9) == 0) ? 16'($urandom_range(40)) : 16'($urandom_range(12));
        make_frame(f, len, 8'($urandom_range(255)), -1);
        if (pick < 55)
            ;
        else if (pick < 63)
            f[$urandom_range(1)] ^= 8'($urandom_range(255, 1));
        else if (pick < 71)
            f[f.size() - 1 - $urandom_range(1)] ^= 8'($urandom_range(255, 1));
        else if (pick < 81)
        begin
            n = $urandom_range(f.size() - 1, 1);
            while (f.size() > n)
                void'(f.pop_back());
        end
        else if (pick < 87)
            repeat ($urandom_range(6, 1)) f.insert(f.size(), 8'($urandom_range(255)));
        else if (pick < 93)
        begin
            // declare a wide length, then cut the buffer short
            f[2] = 8'($urandom_range(255));
            f[3] = 8'($urandom_range(255));
            n = $urandom_range(20, 1);
            while (f.size() > n)
                void'(f.pop_back());
        end
        else
        begin
            f = {};
            repeat ($urandom_range(12, 1)) f.insert(f.size(), 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        octet_q_t    f;
        int          phase_bytes;
        logic [15:0] seeds[5];
        seeds[0] = 16'h0000;
        seeds[1] = 16'hFFFF;
        seeds[2] = 16'($urandom);
        seeds[3] = 16'h1D0F;
        seeds[4] = 16'($urandom);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed buffers under the reset seed
        f = {8'hFF};
        queue_buffer(f);
        make_frame(f, 16'h0000, 8'hFF, -1);
        queue_buffer(f);
        make_frame(f, 16'h0001, 8'h00, 8'hFF);
        f[6] ^= 8'h80;
        queue_buffer(f);
        make_frame(f, 16'h0000, 8'h5A, -1);
        f[1] = 8'h00;
        queue_buffer(f);
        f = {fcp_pkg::MARK0, fcp_pkg::MARK1, 8'h00, 8'h00, 8'h00, 8'h00};
        queue_buffer(f);

        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            write_crc_seed(seeds[ph]);
            @(negedge clk);
            calm = (ph == 2);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                random_buffer(f);
                queue_buffer(f);
                phase_bytes += f.size();
            end
        end

        drain();
        if (fail_count == 0)
            $display("PASS frame_parser_crc16");
        else
            $display("FAIL frame_parser_crc16");
        $finish;
    end

endmodule
